// ===== hdl/wsdfr_pkg.sv =====
package wsdfr_pkg;

	// frame parsing phases
	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXTLEN,
		PH_KEY,
		PH_PAYLOAD,
		PH_CLOSED
	} phase_t;

	typedef enum logic [1:0] {
		ACT_TEXT    = 2'd0,
		ACT_PONG    = 2'd1,
		ACT_CLOSE   = 2'd2,
		ACT_DISCARD = 2'd3
	} action_t;

	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;

	// extended length / key byte counts, minus one
	localparam logic [2:0] LEN16_CNT = 3'd1;
	localparam logic [2:0] LEN64_CNT = 3'd7;
	localparam logic [2:0] KEY_CNT   = 3'd3;

	localparam int QUEUE_DEPTH = 4;

	// one classified item from the parser to the output side
	typedef struct packed {
		logic       has_byte;
		logic [7:0] raw_byte;
		logic [7:0] key_byte;
		logic [3:0] opcode;
		logic       last;
	} entry_t;

	function automatic action_t action_of(input logic [3:0] op);
		action_t a;
		case (op)
			OP_TEXT:  a = ACT_TEXT;
			OP_PING:  a = ACT_PONG;
			OP_CLOSE: a = ACT_CLOSE;
			default:  a = ACT_DISCARD;
		endcase
		return a;
	endfunction

endpackage

// ===== hdl/wsdfr_ifs.sv =====
interface wsdfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface wsdfr_res_if;
	logic       valid;
	logic       ready;
	logic       has_byte;
	logic [7:0] payload_byte;
	logic [3:0] frame_opcode;
	logic [1:0] action;
	logic       last;

	modport source (output valid, output has_byte, output payload_byte,
		output frame_opcode, output action, output last, input ready);
	modport sink (input valid, input has_byte, input payload_byte,
		input frame_opcode, input action, input last, output ready);
endinterface

// ===== hdl/wsdfr_front.sv =====
module wsdfr_front (
	input  logic              clk,
	input  logic              arst_n,
	wsdfr_byte_if.sink        rx,
	input  logic              full,
	output logic              push,
	output wsdfr_pkg::entry_t push_data
);

	wsdfr_pkg::phase_t state_q, state_d;

	logic [3:0]  opcode_q;
	logic        masked_q;
	logic [63:0] len_q;
	logic [2:0]  cnt_q;
	logic [7:0]  key_q [4];
	logic [1:0]  midx_q;

	logic              fire;
	logic [7:0]        b;
	logic [63:0]       ext_len;
	logic [63:0]       hdr_len;
	logic              hdr_len_final;
	logic              key_final;
	logic              len_last;
	logic [7:0]        key_byte;
	wsdfr_pkg::phase_t done_state;
	logic [1:0]        key_slot;

	assign rx.ready = !full;
	assign fire     = rx.valid && rx.ready;
	assign b        = rx.in_byte;

	assign ext_len    = {len_q[55:0], b};
	assign len_last   = (len_q == 64'd1);
	assign key_byte   = masked_q ? key_q[midx_q] : 8'h00;
	assign done_state = (opcode_q == wsdfr_pkg::OP_CLOSE) ? wsdfr_pkg::PH_CLOSED
		: wsdfr_pkg::PH_HDR0;
	assign key_slot   = 2'd3 - cnt_q[1:0];

	// length known at the end of this byte, and whether the header ends here
	always_comb begin
		hdr_len       = len_q;
		hdr_len_final = 1'b0;
		key_final     = 1'b0;
		case (state_q)
			wsdfr_pkg::PH_HDR1: begin
				hdr_len       = {57'd0, b[6:0]};
				hdr_len_final = (b[6:0] != wsdfr_pkg::LEN16_CODE)
					&& (b[6:0] != wsdfr_pkg::LEN64_CODE) && !b[7];
			end
			wsdfr_pkg::PH_EXTLEN: begin
				hdr_len       = ext_len;
				hdr_len_final = (cnt_q == 3'd0) && !masked_q;
			end
			wsdfr_pkg::PH_KEY: begin
				key_final = (cnt_q == 3'd0);
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (fire) begin
			case (state_q)
				wsdfr_pkg::PH_HDR0: state_d = wsdfr_pkg::PH_HDR1;
				wsdfr_pkg::PH_HDR1: begin
					if (b[6:0] == wsdfr_pkg::LEN16_CODE || b[6:0] == wsdfr_pkg::LEN64_CODE)
						state_d = wsdfr_pkg::PH_EXTLEN;
					else if (b[7])
						state_d = wsdfr_pkg::PH_KEY;
					else if (hdr_len == 64'd0)
						state_d = done_state;
					else
						state_d = wsdfr_pkg::PH_PAYLOAD;
				end
				wsdfr_pkg::PH_EXTLEN: begin
					if (cnt_q == 3'd0) begin
						if (masked_q)
							state_d = wsdfr_pkg::PH_KEY;
						else if (hdr_len == 64'd0)
							state_d = done_state;
						else
							state_d = wsdfr_pkg::PH_PAYLOAD;
					end
				end
				wsdfr_pkg::PH_KEY: begin
					if (key_final)
						state_d = (len_q == 64'd0) ? done_state : wsdfr_pkg::PH_PAYLOAD;
				end
				wsdfr_pkg::PH_PAYLOAD: begin
					if (len_last)
						state_d = done_state;
				end
				wsdfr_pkg::PH_CLOSED: state_d = wsdfr_pkg::PH_CLOSED;
				default: state_d = wsdfr_pkg::PH_HDR0;
			endcase
		end
	end

	// queue writes: payload bytes and empty-frame completions
	always_comb begin
		push      = 1'b0;
		push_data = '{has_byte: 1'b0, raw_byte: 8'h00, key_byte: 8'h00,
			opcode: opcode_q, last: 1'b1};
		if (fire) begin
			case (state_q)
				wsdfr_pkg::PH_HDR1, wsdfr_pkg::PH_EXTLEN: begin
					push = hdr_len_final && (hdr_len == 64'd0);
				end
				wsdfr_pkg::PH_KEY: begin
					push = key_final && (len_q == 64'd0);
				end
				wsdfr_pkg::PH_PAYLOAD: begin
					push      = 1'b1;
					push_data = '{has_byte: 1'b1, raw_byte: b, key_byte: key_byte,
						opcode: opcode_q, last: len_last};
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wsdfr_pkg::PH_HDR0;
			opcode_q <= 4'd0;
			masked_q <= 1'b0;
			len_q    <= 64'd0;
			cnt_q    <= 3'd0;
			midx_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				case (state_q)
					wsdfr_pkg::PH_HDR0: opcode_q <= b[3:0];
					wsdfr_pkg::PH_HDR1: begin
						masked_q <= b[7];
						midx_q   <= 2'd0;
						if (b[6:0] == wsdfr_pkg::LEN16_CODE) begin
							len_q <= 64'd0;
							cnt_q <= wsdfr_pkg::LEN16_CNT;
						end else if (b[6:0] == wsdfr_pkg::LEN64_CODE) begin
							len_q <= 64'd0;
							cnt_q <= wsdfr_pkg::LEN64_CNT;
						end else begin
							len_q <= hdr_len;
							cnt_q <= wsdfr_pkg::KEY_CNT;
						end
					end
					wsdfr_pkg::PH_EXTLEN: begin
						len_q <= ext_len;
						cnt_q <= (cnt_q != 3'd0) ? cnt_q - 3'd1 : wsdfr_pkg::KEY_CNT;
					end
					wsdfr_pkg::PH_KEY: begin
						if (cnt_q != 3'd0)
							cnt_q <= cnt_q - 3'd1;
					end
					wsdfr_pkg::PH_PAYLOAD: begin
						len_q  <= len_q - 64'd1;
						midx_q <= midx_q + 2'd1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// key bytes land in order of arrival, byte 0 first
	always_ff @(posedge clk) begin
		if (fire && state_q == wsdfr_pkg::PH_KEY)
			key_q[key_slot] <= b;
	end

	a_no_push_when_closed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wsdfr_pkg::PH_CLOSED |-> !push)
		else $error("item produced after close");

	a_push_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> fire)
		else $error("queue write without an accepted byte");

	a_payload_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wsdfr_pkg::PH_PAYLOAD |-> len_q != 64'd0)
		else $error("payload phase with no bytes left");

	a_key_only_masked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wsdfr_pkg::PH_KEY |-> masked_q)
		else $error("mask key read on unmasked frame");

endmodule

// ===== hdl/wsdfr_queue.sv =====
module wsdfr_queue #(
	parameter int Depth = wsdfr_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wsdfr_pkg::entry_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              pop_valid,
	output wsdfr_pkg::entry_t pop_data
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	wsdfr_pkg::entry_t mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push, do_pop;

	assign full      = (count_q == FullCnt);
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/wsdfr_back.sv =====
module wsdfr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  wsdfr_pkg::entry_t head,
	output logic              pop,
	wsdfr_res_if.source       res
);

	logic       valid_q;
	logic       has_byte_q;
	logic [7:0] payload_byte_q;
	logic [3:0] opcode_q;
	logic [1:0] action_q;
	logic       last_q;

	// output register refills whenever it is empty or being taken
	assign pop = head_valid && (!valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || res.ready)
			valid_q <= head_valid;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			has_byte_q     <= head.has_byte;
			payload_byte_q <= head.raw_byte ^ head.key_byte;
			opcode_q       <= head.opcode;
			action_q       <= 2'(wsdfr_pkg::action_of(head.opcode));
			last_q         <= head.last;
		end
	end

	assign res.valid        = valid_q;
	assign res.has_byte     = has_byte_q;
	assign res.payload_byte = payload_byte_q;
	assign res.frame_opcode = opcode_q;
	assign res.action       = action_q;
	assign res.last         = last_q;

endmodule

// ===== hdl/websocket_frame_deframer.sv =====
// result path: the edge that accepts a byte writes its item into the queue, and
//   the output register loads it from the queue head once it is empty or being taken
// throughput: one byte per cycle while the queue is not full; queue and output register
//   let either side stall without stopping the other until the queue fills or runs empty
// reset: arst_n asynchronous, active low; parser waits for a first header
//   byte, queue and output register come up empty
module websocket_frame_deframer #(
	parameter int QueueDepth = wsdfr_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	wsdfr_byte_if.sink  rx_bytes,
	wsdfr_res_if.source results
);

	// parser -> queue
	logic              push;
	wsdfr_pkg::entry_t push_data;
	logic              full;

	// queue -> output side
	logic              pop;
	logic              head_valid;
	wsdfr_pkg::entry_t head;

	// front: walks the frame header (opcode, lengths, mask key) and turns
	// each payload byte, or an empty frame, into one queue item with its key
	// byte already selected; after a close frame it swallows everything
	wsdfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_bytes),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// short queue decouples parsing from result delivery
	wsdfr_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (head_valid),
		.pop_data  (head)
	);

	// back: unmasks the byte, maps opcode to action, holds the result
	wsdfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res        (results)
	);

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	// ---------------------------------------------------------------
	// run constants
	// ---------------------------------------------------------------
	localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall, fills the block
	localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no handshake on either side
	localparam int TAIL_CYCLES     = 20;    // settle time after the last result

	// how the payload length is written into the header
	typedef enum {FORM_SHORT, FORM_16, FORM_64} len_form_t;

	// one result item as seen on the output channel
	typedef struct packed {
		logic                 has_byte;
		logic [7:0]           payload_byte;
		logic [3:0]           frame_opcode;
		wsdfr_pkg::action_t   action;
		logic                 last;
	} frame_result_t;

	// ---------------------------------------------------------------
	// frame parser mirror and result checker
	// ---------------------------------------------------------------
	class deframe_scoreboard;
		wsdfr_pkg::phase_t phase;
		logic [3:0]        opcode;
		logic              masked;
		logic [63:0]       remaining;
		logic [2:0]        hdr_left;
		logic [31:0]       mask_key;
		logic [1:0]        key_idx;
		frame_result_t     expected_results[$];
		int unsigned       failures;

		function new();
			phase     = wsdfr_pkg::PH_HDR0;
			opcode    = '0;
			masked    = 1'b0;
			remaining = '0;
			hdr_left  = '0;
			mask_key  = '0;
			key_idx   = '0;
			failures  = 0;
		endfunction

		function wsdfr_pkg::action_t action_for(logic [3:0] op);
			wsdfr_pkg::action_t a;
			case (op)
				wsdfr_pkg::OP_TEXT: a = wsdfr_pkg::ACT_TEXT;
				wsdfr_pkg::OP_PING: a = wsdfr_pkg::ACT_PONG;
				wsdfr_pkg::OP_CLOSE: a = wsdfr_pkg::ACT_CLOSE;
				default: a = wsdfr_pkg::ACT_DISCARD;
			endcase
			return a;
		endfunction

		// queue one expected result; the last one of a frame ends it
		function void push_result(logic has, logic [7:0] data, logic last_flag);
			frame_result_t r;
			r.has_byte     = has;
			r.payload_byte = data;
			r.frame_opcode = opcode;
			r.action       = action_for(opcode);
			r.last         = last_flag;
			expected_results.insert(expected_results.size(), r);
			if (last_flag)
				phase = (opcode == wsdfr_pkg::OP_CLOSE) ? wsdfr_pkg::PH_CLOSED
					: wsdfr_pkg::PH_HDR0;
		endfunction

		function void header_complete();
			key_idx = '0;
			if (remaining == 0)
				push_result(1'b0, 8'h00, 1'b1);
			else
				phase = wsdfr_pkg::PH_PAYLOAD;
		endfunction

		function void length_known();
			if (masked) begin
				phase    = wsdfr_pkg::PH_KEY;
				hdr_left = wsdfr_pkg::KEY_CNT;
			end else begin
				header_complete();
			end
		endfunction

		// advance the parser by one accepted byte
		function void note_byte(logic [7:0] b);
			logic [7:0] kb;
			case (phase)
				wsdfr_pkg::PH_HDR0: begin
					opcode = b[3:0];
					phase  = wsdfr_pkg::PH_HDR1;
				end
				wsdfr_pkg::PH_HDR1: begin
					masked   = b[7];
					mask_key = '0;
					if (b[6:0] == wsdfr_pkg::LEN16_CODE || b[6:0] == wsdfr_pkg::LEN64_CODE) begin
						remaining = '0;
						hdr_left  = (b[6:0] == wsdfr_pkg::LEN16_CODE) ? wsdfr_pkg::LEN16_CNT
							: wsdfr_pkg::LEN64_CNT;
						phase     = wsdfr_pkg::PH_EXTLEN;
					end else begin
						remaining = 64'(b[6:0]);
						length_known();
					end
				end
				wsdfr_pkg::PH_EXTLEN: begin
					remaining = {remaining[55:0], b};
					if (hdr_left != 0)
						hdr_left--;
					else
						length_known();
				end
				wsdfr_pkg::PH_KEY: begin
					mask_key[8 * (3 - int'(hdr_left[1:0])) +: 8] = b;
					if (hdr_left != 0)
						hdr_left--;
					else
						header_complete();
				end
				wsdfr_pkg::PH_PAYLOAD: begin
					kb = masked ? mask_key[8 * int'(key_idx) +: 8] : 8'h00;
					key_idx++;
					remaining--;
					push_result(1'b1, b ^ kb, remaining == 0);
				end
				default: begin
				end
			endcase
		endfunction

		function string show(frame_result_t r);
			return $sformatf("has_byte=%0b byte=%02h opcode=%h action=%0d last=%0b",
				r.has_byte, r.payload_byte, r.frame_opcode, r.action, r.last);
		endfunction

		function void note_failure(string msg);
			if (failures < 10)
				$display("mismatch at %0t: %s", $realtime, msg);
			failures++;
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (expected_results.size() == 0) begin
				note_failure({"result with nothing expected: ", show(got)});
				return;
			end
			want = expected_results.pop_front();
			if (got.has_byte !== want.has_byte || got.payload_byte !== want.payload_byte ||
				got.frame_opcode !== want.frame_opcode || got.action !== want.action ||
				got.last !== want.last)
				note_failure({"expected ", show(want), " got ", show(got)});
		endfunction
	endclass

	// ---------------------------------------------------------------
	// clock, reset, channels and the block
	// ---------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	wsdfr_byte_if rx_bytes ();
	wsdfr_res_if  results ();

	websocket_frame_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_bytes (rx_bytes),
		.results  (results)
	);

	deframe_scoreboard sb = new();

	int          src_idle_pct  = 0;   // chance that the sender idles before an item, drawn again after each idle cycle
	int          sink_idle_pct = 0;   // chance per cycle that the receiver is not ready
	bit          hold_off_req  = 1'b0;
	int unsigned bytes_sent    = 0;
	int unsigned quiet_cycles  = 0;

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------

	// offer one byte, with random gaps before it, and wait for the handshake
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_bytes.valid <= 1'b0;
			@(posedge clk);
		end
		rx_bytes.valid   <= 1'b1;
		rx_bytes.in_byte <= b;
		do
			@(posedge clk);
		while (rx_bytes.ready !== 1'b1);
		bytes_sent++;
	endtask

	// header, optional key and random payload of one frame
	task automatic send_frame(input logic [3:0] op, input bit with_key,
		input logic [63:0] len, input len_form_t form);
		logic [31:0] key;
		key = $urandom;
		// upper nibble carries fin and rsv, which the block ignores
		send_byte({4'($urandom_range(15)), op});
		case (form)
			FORM_SHORT: send_byte({with_key, len[6:0]});
			FORM_16: begin
				send_byte({with_key, wsdfr_pkg::LEN16_CODE});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			default: begin
				send_byte({with_key, wsdfr_pkg::LEN64_CODE});
				for (int i = 7; i >= 0; i--)
					send_byte(len[8 * i +: 8]);
			end
		endcase
		if (with_key)
			for (int i = 0; i < 4; i++)
				send_byte(key[8 * i +: 8]);
		for (longint unsigned n = 0; n < len; n++)
			send_byte(8'($urandom));
	endtask

	// random frame, never a close frame; mostly short payloads
	task automatic random_frame();
		logic [3:0]  op;
		bit          with_key;
		logic [63:0] len;
		len_form_t   form;
		int          pick;
		pick = $urandom_range(9);
		if (pick < 4) begin
			op = wsdfr_pkg::OP_TEXT;
		end else if (pick < 6) begin
			op = wsdfr_pkg::OP_PING;
		end else begin
			do
				op = 4'($urandom_range(15));
			while (op == wsdfr_pkg::OP_CLOSE);
		end
		with_key = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 80)
			len = 64'($urandom_range(24));
		else if (pick < 95)
			len = 64'($urandom_range(200, 25));
		else
			len = 64'(125 + $urandom_range(3));   // around the short-length limit
		// non-minimal encodings are legal and get used too
		pick = $urandom_range(99);
		if (len < 126)
			form = (pick < 70) ? FORM_SHORT : ((pick < 85) ? FORM_16 : FORM_64);
		else
			form = (pick < 75) ? FORM_16 : FORM_64;
		send_frame(op, with_key, len, form);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned target;
		target = bytes_sent + count;
		while (bytes_sent < target)
			random_frame();
	endtask

	// stop offering and wait until every expected result has arrived;
	// the extra edge lets the monitor log the last accepted byte first
	task automatic wait_drained();
		rx_bytes.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n           <= 1'b0;
		rx_bytes.valid   <= 1'b0;
		rx_bytes.in_byte <= 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase one: sender idles lightly, receiver heavily
		src_idle_pct  = 24;
		sink_idle_pct = 45;

		// directed frames
		send_frame(wsdfr_pkg::OP_TEXT, 1'b0, 64'd1, FORM_SHORT);   // plain one-byte text
		send_frame(wsdfr_pkg::OP_PING, 1'b0, 64'd0, FORM_SHORT);   // empty, done on the length byte
		send_frame(4'h0, 1'b1, 64'd0, FORM_SHORT);      // empty masked continuation
		send_frame(4'hF, 1'b0, 64'd0, FORM_64);         // empty with 64-bit length
		send_frame(wsdfr_pkg::OP_PING, 1'b1, 64'd3, FORM_16);      // non-minimal 16-bit length

		// receiver stalls for a long time while a frame keeps coming
		hold_off_req = 1'b1;
		send_frame(wsdfr_pkg::OP_TEXT, 1'b1, 64'd48, FORM_SHORT);
		wait_drained();

		run_random(340);
		wait_drained();

		// phase two: the other way round
		src_idle_pct  = 45;
		sink_idle_pct = 24;
		run_random(340);
		wait_drained();

		// phase three: no idling, including lengths that need two length bytes
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		send_frame(wsdfr_pkg::OP_TEXT, 1'b1, 64'd280, FORM_16);
		send_frame(4'h2, 1'b0, 64'd260, FORM_64);
		run_random(340);

		// close frame, then bytes that must all be dropped
		send_frame(wsdfr_pkg::OP_CLOSE, 1'b1, 64'd3, FORM_SHORT);
		send_byte({4'h8, wsdfr_pkg::OP_TEXT});
		send_byte(8'h00);
		repeat (8) send_byte(8'($urandom));

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// receiver side: random ready, or a long hold-off on request
	// ---------------------------------------------------------------
	initial begin
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				results.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				results.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// ---------------------------------------------------------------
	// monitors: log accepted bytes, check accepted results
	// ---------------------------------------------------------------
	always @(posedge clk) begin : watch_ports
		frame_result_t seen;
		if (rx_bytes.valid === 1'b1 && rx_bytes.ready === 1'b1)
			sb.note_byte(rx_bytes.in_byte);
		if (results.valid === 1'b1 && results.ready === 1'b1) begin
			seen.has_byte     = results.has_byte;
			seen.payload_byte = results.payload_byte;
			seen.frame_opcode = results.frame_opcode;
			seen.action       = wsdfr_pkg::action_t'(results.action);
			seen.last         = results.last;
			sb.check_result(seen);
		end
	end

	// watchdog: too long without any handshake means the block is stuck
	always @(posedge clk) begin
		if ((rx_bytes.valid === 1'b1 && rx_bytes.ready === 1'b1) ||
			(results.valid === 1'b1 && results.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

// ===== filelist.f =====
hdl/wsdfr_pkg.sv
hdl/wsdfr_ifs.sv
hdl/wsdfr_front.sv
hdl/wsdfr_queue.sv
hdl/wsdfr_back.sv
hdl/websocket_frame_deframer.sv
verif/tb_top.sv
